FILE: hdl/assert_macros.svh
// Assertion helpers for the checker in pmq_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, ignored while reset is high.
`define PMQ_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define PMQ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/pmq_pkg.sv
`default_nettype none

package pmq_pkg;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_GET   = 2'd1;
  localparam logic [1:0] OP_PEEK  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_BAD_PRIO = 2'd3;

  // Reset value of the pool size register.
  localparam int NODES_RESET = 32;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  priority_req;
    logic [3:0]  msg_len;
    logic [63:0] payload_in;
    logic [3:0]  read_limit;
  } pmq_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  length_out;
    logic [63:0] payload_out;
    logic [2:0]  served_level;
  } pmq_rsp_t;

  // Keep the low len bytes, zero the rest.
  function automatic logic [63:0] byte_mask(input logic [3:0] len);
    logic [63:0] mask;
    mask = '0;
    for (int b = 0; b < 8; b++) begin
      mask[b*8 +: 8] = (4'(b) < len) ? 8'hFF : 8'h00;
    end
    return mask;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/pmq_ram.sv
`default_nettype none

module pmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                    clk,
  input  wire logic                                    wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                        wr_data,
  input  wire logic                                    rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/priority_message_queue.sv
// Priority message queue.
// Request channel (req_valid / req_stall / req): one operation per transfer,
// put, get, peek or clear. Response channel (rsp_valid / rsp_stall / rsp):
// exactly one response per request, in request order.
// Configuration: cfg_write with cfg_data sets the pool size used by the next
// clear; write it only while the block is idle.
// Timing: a request is taken in IDLE, which also starts reads of the node,
// link and tail memories; in EXEC the read data is used to finish the
// operation and load the response register. The next request is taken
// only after EXEC has finished; rsp_valid rises when EXEC finishes.
// The response register parts the two sides: the next request is taken
// while a response waits. If the receiver stalls and the response register
// is still full, the execute cycle holds until it drains.
// Reset (rst, synchronous): all levels empty, free list rebuilt over
// min(32, NODE_COUNT) nodes, pool size register at 32. Free links are
// tracked by a fresh mark, so neither reset nor clear sweeps the memories.
`default_nettype none

module priority_message_queue import pmq_pkg::*; #(
  parameter int NODE_COUNT  = 32,
  parameter int PRIO_LEVELS = 8,
  parameter int MSG_BYTES   = 8
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_stall,
  input  wire pmq_req_t req,
  output logic          rsp_valid,
  input  wire logic     rsp_stall,
  output pmq_rsp_t      rsp,
  input  wire logic     cfg_write,
  input  wire logic [5:0] cfg_data
);

  localparam int NW = $clog2(NODE_COUNT);
  localparam int CW = $clog2(NODE_COUNT + 1);
  localparam int LW = (PRIO_LEVELS > 1) ? $clog2(PRIO_LEVELS) : 1;
  localparam int RESET_POOL = (NODES_RESET > NODE_COUNT) ? NODE_COUNT : NODES_RESET;
  localparam logic [3:0] MAX_LEN = 4'(MSG_BYTES);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  logic [5:0] cfg_nodes;
  logic [NW-1:0] free_head;
  logic [CW-1:0] free_count;
  logic [CW-1:0] fresh;           // nodes at or above this index still hold link i+1 (0 for the last node)
  logic [PRIO_LEVELS-1:0] nonempty;
  logic [NW-1:0] level_head [PRIO_LEVELS];

  pmq_req_t req_q;
  logic [NW-1:0] req_node;
  logic [LW-1:0] req_level;

  // Accept side
  logic accept;
  logic is_put_in;
  logic [LW-1:0] prio_idx;
  logic [LW-1:0] lo_level;
  logic [NW-1:0] get_node;
  logic [3:0] len_sat;
  logic put_store;

  // Memory read data
  logic [67:0] node_rd;
  logic [NW-1:0] link_rd;
  logic [NW-1:0] tail_rd;

  // Execute side
  logic done;
  logic do_put;
  logic do_get;
  logic do_clear;
  logic node_fresh;
  logic [NW-1:0] link_val;
  logic [3:0] stored_len;
  logic [3:0] deliver_len;
  logic [CW-1:0] pool_size;
  pmq_rsp_t rsp_next;

  logic link_wr_en;
  logic [NW-1:0] link_wr_addr;
  logic [NW-1:0] link_wr_data;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && (state == S_IDLE);
  assign is_put_in = (req.opcode == OP_PUT);
  assign prio_idx  = LW'(req.priority_req);

  always_comb begin
    lo_level = '0;
    for (int i = PRIO_LEVELS - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        lo_level = LW'(i);
      end
    end
  end

  assign get_node  = level_head[lo_level];
  assign len_sat   = (req.msg_len > MAX_LEN) ? MAX_LEN : req.msg_len;
  assign put_store = accept && is_put_in && (int'(req.priority_req) < PRIO_LEVELS)
                     && (free_count != '0);

  // Node payload and length: store at take-in, the free head is known already.
  pmq_ram #(.WIDTH(68), .DEPTH(NODE_COUNT)) u_node_ram (
    .clk     (clk),
    .wr_en   (put_store),
    .wr_addr (free_head),
    .wr_data ({len_sat, req.payload_in & byte_mask(len_sat)}),
    .rd_en   (accept),
    .rd_addr (get_node),
    .rd_data (node_rd)
  );

  pmq_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_link_ram (
    .clk     (clk),
    .wr_en   (link_wr_en),
    .wr_addr (link_wr_addr),
    .wr_data (link_wr_data),
    .rd_en   (accept),
    .rd_addr (is_put_in ? free_head : get_node),
    .rd_data (link_rd)
  );

  pmq_ram #(.WIDTH(NW), .DEPTH(PRIO_LEVELS)) u_tail_ram (
    .clk     (clk),
    .wr_en   (done && do_put),
    .wr_addr (req_level),
    .wr_data (req_node),
    .rd_en   (accept),
    .rd_addr (is_put_in ? prio_idx : lo_level),
    .rd_data (tail_rd)
  );

  // Execute: read data is valid, decide and write back.
  assign done       = (state == S_EXEC) && (!rsp_valid || !rsp_stall);
  assign node_fresh = (CW'(req_node) >= fresh);
  assign link_val   = !node_fresh ? link_rd :
                      (int'(req_node) == NODE_COUNT - 1) ? '0 : req_node + 1'b1;
  assign stored_len = node_rd[67:64];
  assign deliver_len = (req_q.read_limit < stored_len) ? req_q.read_limit : stored_len;
  assign pool_size  = (int'(cfg_nodes) > NODE_COUNT) ? CW'(NODE_COUNT) : CW'(cfg_nodes);

  always_comb begin
    rsp_next = '0;
    do_put   = 1'b0;
    do_get   = 1'b0;
    do_clear = 1'b0;
    case (req_q.opcode)
      OP_PUT: begin
        if (int'(req_q.priority_req) >= PRIO_LEVELS) begin
          rsp_next.status = ST_BAD_PRIO;
        end else if (free_count == '0) begin
          rsp_next.status = ST_FULL;
        end else begin
          do_put = 1'b1;
        end
      end
      OP_GET: begin
        if (nonempty == '0) begin
          rsp_next.status = ST_EMPTY;
        end else begin
          do_get                = 1'b1;
          rsp_next.length_out   = deliver_len;
          rsp_next.payload_out  = node_rd[63:0] & byte_mask(deliver_len);
          rsp_next.served_level = 3'(req_level);
        end
      end
      OP_PEEK: begin
        if (nonempty == '0) begin
          rsp_next.status = ST_EMPTY;
        end else begin
          rsp_next.length_out   = stored_len;
          rsp_next.served_level = 3'(req_level);
        end
      end
      default: begin
        do_clear = 1'b1;
      end
    endcase
  end

  // Put appends behind the old tail; get pushes the node onto the free list.
  assign link_wr_en   = done && ((do_put && nonempty[req_level]) || do_get);
  assign link_wr_addr = do_put ? tail_rd : req_node;
  assign link_wr_data = do_put ? req_node : free_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cfg_nodes  <= 6'(NODES_RESET);
      free_head  <= '0;
      free_count <= CW'(RESET_POOL);
      fresh      <= '0;
      nonempty   <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        cfg_nodes <= cfg_data;
      end
      if (done) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (done) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (done && do_put) begin
        free_head  <= link_val;
        free_count <= free_count - 1'b1;
        if (node_fresh) begin
          fresh <= fresh + 1'b1;
        end
        nonempty[req_level] <= 1'b1;
      end
      if (done && do_get) begin
        if (tail_rd == req_node) begin
          nonempty[req_level] <= 1'b0;
        end
        free_head <= req_node;
        if (int'(free_count) < NODE_COUNT) begin
          free_count <= free_count + 1'b1;
        end
      end
      if (done && do_clear) begin
        free_head  <= '0;
        free_count <= pool_size;
        fresh      <= '0;
        nonempty   <= '0;
      end
    end
  end

  // Level heads: only read where the bitmap marks the level, so no reset.
  always_ff @(posedge clk) begin
    if (done && do_put && !nonempty[req_level]) begin
      level_head[req_level] <= req_node;
    end
    if (done && do_get && (tail_rd != req_node)) begin
      level_head[req_level] <= link_val;
    end
  end

  // Hold the request and the chosen node and level for the execute cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q     <= req;
      req_node  <= is_put_in ? free_head : get_node;
      req_level <= is_put_in ? prio_idx : lo_level;
    end
    if (done) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/pmq_checker.sv
`default_nettype none
`include "assert_macros.svh"

module pmq_checker import pmq_pkg::*; (
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     req_valid,
  input wire logic     req_stall,
  input wire logic     rsp_valid,
  input wire logic     rsp_stall,
  input wire pmq_rsp_t rsp
);

  `PMQ_ASSERT_ALWAYS(a_reset_no_rsp, clk, rst |=> !rsp_valid, "response valid after reset")

  `PMQ_ASSERT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "stalled response changed")

  `PMQ_ASSERT(a_busy_after_take, clk, rst, req_valid && !req_stall |=> req_stall, "second request taken while busy")

  `PMQ_ASSERT(a_error_zero, clk, rst, rsp_valid && (rsp.status != ST_OK) |-> (rsp.length_out == 4'd0) && (rsp.payload_out == 64'd0) && (rsp.served_level == 3'd0), "error response carries data")

  `PMQ_ASSERT(a_payload_masked, clk, rst, rsp_valid |-> ((rsp.payload_out & ~byte_mask(rsp.length_out)) == 64'd0), "bytes beyond length not zero")

endmodule

bind priority_message_queue pmq_checker u_pmq_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire
